// ===== hw/rtl/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants for the sensor alarm classifier
// Field layouts, operation, state and reason codes, register indexes.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int AXES = 6;

  // invalid samples in a row before the fault state
  localparam logic [1:0] FAULT_LIMIT = 2'd3;
  localparam logic [1:0] RUN_MAX     = 2'd3;

  // operation codes
  localparam logic [2:0] OP_KEY_CLEAR = 3'd1;
  localparam logic [2:0] OP_MUTE      = 3'd2;
  localparam logic [2:0] OP_ACK       = 3'd3;
  localparam logic [2:0] OP_DEMO      = 3'd4;

  // classification states; NONE only lives in the tracked last state
  localparam logic [2:0] ST_NORMAL  = 3'd0;
  localparam logic [2:0] ST_WARNING = 3'd1;
  localparam logic [2:0] ST_ALARM   = 3'd2;
  localparam logic [2:0] ST_FAULT   = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  // reason codes
  localparam logic [3:0] RSN_NONE         = 4'd0;
  localparam logic [3:0] RSN_LIGHT_FAULT  = 4'd1;
  localparam logic [3:0] RSN_MOTION_FAULT = 4'd2;
  localparam logic [3:0] RSN_MOTION_ALARM = 4'd3;
  localparam logic [3:0] RSN_PROX_ALARM   = 4'd4;
  localparam logic [3:0] RSN_ALARM        = 4'd5;
  localparam logic [3:0] RSN_MOTION_WARN  = 4'd6;
  localparam logic [3:0] RSN_LOW_LIGHT    = 4'd7;
  localparam logic [3:0] RSN_PROX_WARN    = 4'd8;
  localparam logic [3:0] RSN_WARNING      = 4'd9;

  // configuration register indexes
  localparam logic [2:0] REG_MOTION_ALARM = 3'd0;
  localparam logic [2:0] REG_MOTION_WARN  = 3'd1;
  localparam logic [2:0] REG_PROX_ALARM   = 3'd2;
  localparam logic [2:0] REG_PROX_WARN    = 3'd3;
  localparam logic [2:0] REG_LIGHT_LOW    = 3'd4;

  localparam logic [18:0] RST_MOTION_ALARM = 19'd15000;
  localparam logic [18:0] RST_MOTION_WARN  = 19'd8000;
  localparam logic [9:0]  RST_PROX_ALARM   = 10'd220;
  localparam logic [9:0]  RST_PROX_WARN    = 10'd120;
  localparam logic [15:0] RST_LIGHT_LOW    = 16'd80;

  typedef logic [AXES-1:0][15:0] axes_t;

  typedef struct packed {
    logic [2:0]  op;
    axes_t       axes;
    logic        motion_valid;
    logic [15:0] ambient_light;
    logic [9:0]  proximity;
    logic        light_valid;
  } sample_t;

  typedef struct packed {
    logic [18:0] move_alarm;
    logic [18:0] move_warn;
    logic [9:0]  prox_alarm;
    logic [9:0]  prox_warn;
    logic [15:0] light_low;
  } limits_t;

  // tracked classification state
  typedef struct packed {
    logic [1:0]  invalid_run;
    logic [2:0]  prior_grade;
    logic [15:0] alarm_total;
    logic        mute_flag;
    logic        ack_flag;
    logic [18:0] last_delta;
  } track_t;

  typedef struct packed {
    logic [1:0]  grade;
    logic [3:0]  reason;
    logic [18:0] delta_sum;
    logic [15:0] alarm_count;
    logic        muted;
    logic        acknowledged;
    logic        state_changed;
  } result_t;

endpackage

// ===== hw/rtl/sac_motion.sv =====
// ----------------------------------------------------------------------------
// sac_motion: motion delta
// Sum of absolute axis differences against the previous sample, zero unless
// both samples carry a good inertial read.
// ----------------------------------------------------------------------------
module sac_motion
  import sac_pkg::*;
(
  input  axes_t       cur_axes,
  input  axes_t       prev_axes,
  input  logic        cur_valid,
  input  logic        prev_valid,
  output logic [18:0] delta
);

  logic signed [16:0] diff [AXES];
  logic [15:0]        mag  [AXES];
  logic [18:0]        sum;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      diff[i] = $signed({cur_axes[i][15], cur_axes[i]})
              - $signed({prev_axes[i][15], prev_axes[i]});
      // magnitude never exceeds 65535, so 16 bits hold it
      mag[i]  = diff[i][16] ? 16'(-diff[i]) : diff[i][15:0];
    end
    sum = '0;
    for (int i = 0; i < AXES; i++) begin
      sum = sum + {3'b000, mag[i]};
    end
    delta = (cur_valid && prev_valid) ? sum : '0;
  end

endmodule

// ===== hw/rtl/sac_grade.sv =====
// ----------------------------------------------------------------------------
// sac_grade: grading and command handling
// Classifies one sample, applies the operation and works out the next
// tracked state and the result fields.
// ----------------------------------------------------------------------------
module sac_grade
  import sac_pkg::*;
(
  input  sample_t     smp,
  input  logic [18:0] delta,
  input  limits_t     lim,
  input  track_t      trk,
  output track_t      trk_next,
  output result_t     res
);

  logic        mv;
  logic        lv;
  logic [15:0] als;
  logic [9:0]  ps;
  logic [18:0] dly;
  logic [2:0]  st_eval;
  logic [2:0]  st_fin;
  logic [2:0]  last_eff;
  logic        fault;
  logic        entry;
  logic        demo;
  logic        changed;
  logic [1:0]  inc;
  logic [16:0] total_sum;
  logic [3:0]  rsn;

  always_comb begin
    mv  = smp.motion_valid;
    lv  = smp.light_valid;
    als = lv ? smp.ambient_light : '0;
    ps  = lv ? smp.proximity : '0;

    trk_next = trk;
    fault    = 1'b0;
    st_eval  = ST_NORMAL;

    if (smp.op == OP_KEY_CLEAR) begin
      // no grading; stale delta and run count stay
      dly                = trk.last_delta;
      trk_next.ack_flag  = 1'b1;
      trk_next.mute_flag = 1'b1;
      last_eff           = ST_NONE;
    end else begin
      dly                 = delta;
      trk_next.last_delta = delta;
      if (!mv || !lv) begin
        trk_next.invalid_run = (trk.invalid_run == RUN_MAX) ? RUN_MAX
                                                            : trk.invalid_run + 2'd1;
        fault = (trk_next.invalid_run >= FAULT_LIMIT);
      end else begin
        trk_next.invalid_run = '0;
      end
      last_eff = trk.prior_grade;
      if (fault) begin
        st_eval = ST_FAULT;
      end else if (delta > lim.move_alarm) begin
        st_eval = ST_ALARM;
      end else if (lv && ps > lim.prox_alarm) begin
        st_eval = ST_ALARM;
      end else if (delta > lim.move_warn) begin
        st_eval = ST_WARNING;
      end else if (lv && als < lim.light_low) begin
        st_eval = ST_WARNING;
      end else if (lv && ps > lim.prox_warn) begin
        st_eval = ST_WARNING;
      end
    end

    entry = (st_eval != ST_NORMAL) && (last_eff == ST_NORMAL);
    if (entry) begin
      trk_next.ack_flag  = 1'b0;
      trk_next.mute_flag = 1'b0;
    end
    changed = (st_eval != last_eff) && (last_eff != ST_NONE);

    st_fin = st_eval;
    demo   = 1'b0;
    case (smp.op)
      OP_MUTE: begin
        trk_next.mute_flag = 1'b1;
      end
      OP_ACK: begin
        trk_next.ack_flag  = 1'b1;
        trk_next.mute_flag = 1'b1;
        st_fin             = ST_NORMAL;
      end
      OP_DEMO: begin
        demo               = 1'b1;
        trk_next.ack_flag  = 1'b0;
        trk_next.mute_flag = 1'b0;
        st_fin             = ST_ALARM;
      end
      default: begin
      end
    endcase

    // entry and demo may both count; two saturating steps equal one clamp
    inc       = {1'b0, entry} + {1'b0, demo};
    total_sum = {1'b0, trk.alarm_total} + {15'd0, inc};
    trk_next.alarm_total = total_sum[16] ? 16'hFFFF : total_sum[15:0];
    trk_next.prior_grade = st_fin;

    case (st_fin)
      ST_FAULT: begin
        rsn = mv ? RSN_LIGHT_FAULT : RSN_MOTION_FAULT;
      end
      ST_ALARM: begin
        if (dly != '0)     rsn = RSN_MOTION_ALARM;
        else if (ps != '0) rsn = RSN_PROX_ALARM;
        else               rsn = RSN_ALARM;
      end
      ST_WARNING: begin
        if (dly != '0)      rsn = RSN_MOTION_WARN;
        else if (als != '0) rsn = RSN_LOW_LIGHT;
        else if (ps != '0)  rsn = RSN_PROX_WARN;
        else                rsn = RSN_WARNING;
      end
      default: begin
        rsn = RSN_NONE;
      end
    endcase

    res.grade         = st_fin[1:0];
    res.reason        = rsn;
    res.delta_sum     = dly;
    res.alarm_count   = trk_next.alarm_total;
    res.muted         = trk_next.mute_flag;
    res.acknowledged  = trk_next.ack_flag;
    res.state_changed = changed;
  end

endmodule

// ===== hw/rtl/sensor_alarm_classifier.sv =====
// ----------------------------------------------------------------------------
// sensor_alarm_classifier: sensor sample grading with alarm bookkeeping
// Grades each sample as normal, warning, alarm or fault and keeps the alarm
// count, mute and acknowledge flags.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  sample    sample_valid/sample_stall op, six axes, valids, light, proximity
//  result    result_valid/result_stall state, reason, delta, count, flags
//  config    cfg_valid/cfg_ready       cfg_index, cfg_data
//
//  A sample goes through an input register and a result register, one
//  transaction per cycle sustained while the result side does not stall.
//  The tracked state moves when a sample passes into the result register,
//  so the next sample in the input register already sees it.
//  Stalls on the result side back up into sample_stall only when both
//  registers are full. Synchronous reset; cfg_ready is always high.
// ----------------------------------------------------------------------------
module sensor_alarm_classifier
  import sac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [2:0]         op,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  input  logic               motion_valid,
  input  logic [15:0]        ambient_light,
  input  logic [9:0]         proximity,
  input  logic               light_valid,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         grade,
  output logic [3:0]         reason,
  output logic [18:0]        delta_sum,
  output logic [15:0]        alarm_count,
  output logic               muted,
  output logic               acknowledged,
  output logic               state_changed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [18:0]        cfg_data
);

  sample_t     smp_in;
  sample_t     smp;
  logic        smp_valid;
  logic        advance;
  logic        accept;
  axes_t       prev_axes;
  logic        prev_valid;
  track_t      trk;
  track_t      trk_next;
  limits_t     lim;
  result_t     res;
  result_t     res_next;
  logic [18:0] delta;

  always_comb begin
    smp_in.op            = op;
    smp_in.axes[0]       = accel_x;
    smp_in.axes[1]       = accel_y;
    smp_in.axes[2]       = accel_z;
    smp_in.axes[3]       = gyro_x;
    smp_in.axes[4]       = gyro_y;
    smp_in.axes[5]       = gyro_z;
    smp_in.motion_valid  = motion_valid;
    smp_in.ambient_light = ambient_light;
    smp_in.proximity     = proximity;
    smp_in.light_valid   = light_valid;
  end

  assign advance      = smp_valid && (!result_valid || !result_stall);
  assign sample_stall = smp_valid && result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;
  assign cfg_ready    = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lim.move_alarm <= RST_MOTION_ALARM;
      lim.move_warn  <= RST_MOTION_WARN;
      lim.prox_alarm <= RST_PROX_ALARM;
      lim.prox_warn  <= RST_PROX_WARN;
      lim.light_low  <= RST_LIGHT_LOW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MOTION_ALARM: lim.move_alarm <= cfg_data;
        REG_MOTION_WARN:  lim.move_warn  <= cfg_data;
        REG_PROX_ALARM:   lim.prox_alarm <= cfg_data[9:0];
        REG_PROX_WARN:    lim.prox_warn  <= cfg_data[9:0];
        REG_LIGHT_LOW:    lim.light_low  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (accept) begin
      smp_valid <= 1'b1;
    end else if (advance) begin
      smp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= smp_in;
    end
  end

  sac_motion u_motion (
    .cur_axes   (smp.axes),
    .prev_axes  (prev_axes),
    .cur_valid  (smp.motion_valid),
    .prev_valid (prev_valid),
    .delta      (delta)
  );

  sac_grade u_grade (
    .smp      (smp),
    .delta    (delta),
    .lim      (lim),
    .trk      (trk),
    .trk_next (trk_next),
    .res      (res_next)
  );

  // tracked state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_axes        <= '0;
      prev_valid       <= 1'b0;
      trk.invalid_run  <= '0;
      trk.prior_grade  <= ST_NONE;
      trk.alarm_total  <= '0;
      trk.mute_flag    <= 1'b0;
      trk.ack_flag     <= 1'b0;
      trk.last_delta   <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (advance) begin
        prev_axes    <= smp.axes;
        prev_valid   <= smp.motion_valid;
        trk          <= trk_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign grade         = res.grade;
  assign reason        = res.reason;
  assign delta_sum     = res.delta_sum;
  assign alarm_count   = res.alarm_count;
  assign muted         = res.muted;
  assign acknowledged  = res.acknowledged;
  assign state_changed = res.state_changed;

`ifndef SYNTHESIS
  // the alarm count only grows between resets
  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> trk.alarm_total >= $past(trk.alarm_total))
    else $error("alarm count went down");

  // once a sample has been graded the none marker is gone
  a_last_state_known: assert property (@(posedge clk) disable iff (rst)
    advance |=> trk.prior_grade != ST_NONE)
    else $error("last state left at none after a transaction");

  // a fault result always goes with a full invalid run
  a_fault_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && res.grade == ST_FAULT[1:0] |-> trk.invalid_run >= FAULT_LIMIT)
    else $error("fault reported without enough invalid samples");

  // the input stage only stalls when it holds a sample
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> smp_valid && result_valid)
    else $error("sample stall with nothing held");
`endif

endmodule

// ===== dv/tb_sensor_alarm_classifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_alarm_classifier: self-checking bench for the alarm classifier
// Directed samples, then random sample streams under several limit settings.
// A local grading model predicts every result; random bursts and gaps on
// the sample channel, random stalls on the result channel.
// ----------------------------------------------------------------------------
module tb_sensor_alarm_classifier;
  import sac_pkg::*;

  localparam logic [2:0] OP_SAMPLE   = 3'd0;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [2:0] REG_SPARE   = 3'd7;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_LEN   = 120;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  logic [2:0]         op = '0;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic signed [15:0] gyro_x = '0;
  logic signed [15:0] gyro_y = '0;
  logic signed [15:0] gyro_z = '0;
  logic               motion_valid = 1'b0;
  logic [15:0]        ambient_light = '0;
  logic [9:0]         proximity = '0;
  logic               light_valid = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         grade;
  logic [3:0]         reason;
  logic [18:0]        delta_sum;
  logic [15:0]        alarm_count;
  logic               muted;
  logic               acknowledged;
  logic               state_changed;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [18:0]        cfg_data = '0;

  sensor_alarm_classifier uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // grading model state
  limits_t     lim = '{RST_MOTION_ALARM, RST_MOTION_WARN, RST_PROX_ALARM,
                       RST_PROX_WARN, RST_LIGHT_LOW};
  axes_t       prev_axes = '0;
  logic        prev_ok = 1'b0;
  logic [1:0]  bad_run = '0;
  logic [2:0]  last_st = ST_NONE;
  logic [15:0] alarm_tally = '0;
  logic        mute_f = 1'b0;
  logic        ack_f = 1'b0;
  logic [18:0] held_delta = '0;

  sample_t samples_q[$];
  result_t graded_q[$];
  axes_t   gen_axes = '0;
  int unsigned err_count = 0;
  int unsigned results_seen = 0;

  function automatic void bump_tally();
    if (alarm_tally != '1) alarm_tally++;
  endfunction

  function automatic result_t classify_sample(sample_t s);
    result_t     r;
    logic [15:0] als;
    logic [9:0]  ps;
    logic [2:0]  st;
    logic        pv, fault, chg;
    int          dsum, cur, old;
    als = s.light_valid ? s.ambient_light : '0;
    ps  = s.light_valid ? s.proximity : '0;
    pv  = prev_ok;
    dsum = 0;
    for (int i = 0; i < AXES; i++) begin
      cur = $signed(s.axes[i]);
      old = $signed(prev_axes[i]);
      dsum += (cur > old) ? cur - old : old - cur;
      prev_axes[i] = s.axes[i];
    end
    if (!s.motion_valid || !pv) dsum = 0;
    prev_ok = s.motion_valid;

    if (s.op == OP_KEY_CLEAR) begin
      st = ST_NORMAL;
      ack_f = 1'b1;
      mute_f = 1'b1;
      last_st = ST_NONE;
    end else begin
      held_delta = 19'(dsum);
      fault = 1'b0;
      if (!s.motion_valid || !s.light_valid) begin
        if (bad_run != RUN_MAX) bad_run++;
        fault = (bad_run >= FAULT_LIMIT);
      end else begin
        bad_run = '0;
      end
      if (fault) st = ST_FAULT;
      else if (held_delta > lim.move_alarm) st = ST_ALARM;
      else if (s.light_valid && ps > lim.prox_alarm) st = ST_ALARM;
      else if (held_delta > lim.move_warn) st = ST_WARNING;
      else if (s.light_valid && als < lim.light_low) st = ST_WARNING;
      else if (s.light_valid && ps > lim.prox_warn) st = ST_WARNING;
      else st = ST_NORMAL;
    end

    if (st != ST_NORMAL && last_st == ST_NORMAL) begin
      bump_tally();
      ack_f = 1'b0;
      mute_f = 1'b0;
    end
    chg = (st != last_st) && (last_st != ST_NONE);

    case (s.op)
      OP_MUTE: mute_f = 1'b1;
      OP_ACK: begin
        ack_f = 1'b1;
        mute_f = 1'b1;
        st = ST_NORMAL;
      end
      OP_DEMO: begin
        bump_tally();
        ack_f = 1'b0;
        mute_f = 1'b0;
        st = ST_ALARM;
      end
      default: ;
    endcase

    case (st)
      ST_FAULT: r.reason = s.motion_valid ? RSN_LIGHT_FAULT : RSN_MOTION_FAULT;
      ST_ALARM: begin
        if (held_delta != 0) r.reason = RSN_MOTION_ALARM;
        else if (ps != 0) r.reason = RSN_PROX_ALARM;
        else r.reason = RSN_ALARM;
      end
      ST_WARNING: begin
        if (held_delta != 0) r.reason = RSN_MOTION_WARN;
        else if (als != 0) r.reason = RSN_LOW_LIGHT;
        else if (ps != 0) r.reason = RSN_PROX_WARN;
        else r.reason = RSN_WARNING;
      end
      default: r.reason = RSN_NONE;
    endcase
    r.grade         = st[1:0];
    r.delta_sum     = held_delta;
    r.alarm_count   = alarm_tally;
    r.muted         = mute_f;
    r.acknowledged  = ack_f;
    r.state_changed = chg;
    last_st = st;
    return r;
  endfunction

  // ---- stimulus generation ----
  function automatic sample_t mk(logic [2:0] code, int axis, logic mv, int light,
                                 int prox, logic lv);
    sample_t s;
    s.op = code;
    for (int i = 0; i < AXES; i++) s.axes[i] = 16'(axis);
    s.motion_valid  = mv;
    s.ambient_light = 16'(light);
    s.proximity     = 10'(prox);
    s.light_valid   = lv;
    return s;
  endfunction

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int pick, jit, v;
    pick = $urandom_range(0, 99);
    if (pick < 62) s.op = OP_SAMPLE;
    else if (pick < 70) s.op = OP_MUTE;
    else if (pick < 78) s.op = OP_ACK;
    else if (pick < 85) s.op = OP_DEMO;
    else if (pick < 92) s.op = OP_KEY_CLEAR;
    else s.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    case ($urandom_range(0, 2))
      0: jit = 50;
      1: jit = 1500;
      default: jit = 4000;
    endcase
    pick = $urandom_range(0, 99);
    for (int i = 0; i < AXES; i++) begin
      if (pick < 20) begin
        gen_axes[i] = 16'($urandom);
      end else if (pick < 80) begin
        v = $signed(gen_axes[i]) + int'($urandom_range(0, 2 * jit)) - jit;
        gen_axes[i] = 16'(clampi(v, -32768, 32767));
      end
    end
    s.axes = gen_axes;
    s.motion_valid = ($urandom_range(0, 99) < 87);
    s.light_valid  = ($urandom_range(0, 99) < 87);
    if ($urandom_range(0, 1))
      s.ambient_light = 16'($urandom);
    else
      s.ambient_light = 16'(clampi(int'(lim.light_low) + int'($urandom_range(0, 80)) - 40,
                                   0, 65535));
    case ($urandom_range(0, 2))
      0: s.proximity = 10'($urandom);
      1: s.proximity = 10'(clampi(int'(lim.prox_warn) + int'($urandom_range(0, 40)) - 20,
                                  0, 1023));
      default: s.proximity = 10'(clampi(int'(lim.prox_alarm) + int'($urandom_range(0, 40))
                                        - 20, 0, 1023));
    endcase
    return s;
  endfunction

  task automatic load_random(int n);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        // train of failed reads, long enough to reach the fault state
        repeat ($urandom_range(3, 5)) begin
          s = rand_sample();
          s.op = OP_SAMPLE;
          if ($urandom_range(0, 1)) s.motion_valid = 1'b0;
          else s.light_valid = 1'b0;
          samples_q.push_back(s);
        end
      end
      samples_q.push_back(rand_sample());
    end
  endtask

  task automatic load_directed();
    samples_q.push_back(mk(OP_SAMPLE, 0, 1, 1000, 0, 1));
    samples_q.push_back(mk(OP_SAMPLE, 32767, 1, 65535, 0, 1));
    samples_q.push_back(mk(OP_SAMPLE, -32768, 1, 65535, 0, 1));
    samples_q.push_back(mk(OP_SAMPLE, -32768, 1, 1000, 1023, 1));
    samples_q.push_back(mk(OP_SAMPLE, -30768, 1, 1000, 0, 1));
    samples_q.push_back(mk(OP_SAMPLE, -30768, 1, 1000, 150, 1));
    samples_q.push_back(mk(OP_SAMPLE, -30768, 1, 0, 0, 1));
    samples_q.push_back(mk(OP_SAMPLE, -30768, 1, 0, 150, 1));
    samples_q.push_back(mk(OP_SAMPLE, -30768, 1, 50, 0, 1));
    // light read failed: light and proximity count as zero
    samples_q.push_back(mk(OP_SAMPLE, 0, 1, 65535, 1023, 0));
    samples_q.push_back(mk(OP_SAMPLE, 0, 0, 100, 0, 1));
    samples_q.push_back(mk(OP_SAMPLE, 0, 0, 100, 0, 1));
    samples_q.push_back(mk(OP_SAMPLE, 0, 1, 100, 500, 0));
    samples_q.push_back(mk(OP_SAMPLE, 0, 1, 100, 0, 1));
    samples_q.push_back(mk(OP_MUTE, 0, 1, 0, 0, 1));
    samples_q.push_back(mk(OP_ACK, 0, 1, 100, 0, 1));
    samples_q.push_back(mk(OP_DEMO, 0, 1, 100, 0, 1));
    samples_q.push_back(mk(OP_KEY_CLEAR, 1000, 1, 0, 1023, 1));
    samples_q.push_back(mk(OP_SAMPLE, 1000, 1, 0, 1023, 1));
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
      samples_q.push_back(mk(3'(c), 1000, 1, 100, 130, 1));
    samples_q.push_back(mk(OP_SAMPLE, 1000, 1, 0, 0, 1));
    samples_q.push_back(mk(OP_MUTE, 4000, 1, 100, 0, 1));
  endtask

  // ---- configuration ----
  task automatic write_reg(logic [2:0] idx, logic [18:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MOTION_ALARM: lim.move_alarm = data;
      REG_MOTION_WARN:  lim.move_warn  = data;
      REG_PROX_ALARM:   lim.prox_alarm = data[9:0];
      REG_PROX_WARN:    lim.prox_warn  = data[9:0];
      REG_LIGHT_LOW:    lim.light_low  = data[15:0];
      default: ;
    endcase
  endtask

  task automatic program_limits(int k);
    logic [18:0] v [5];
    case (k)
      0: foreach (v[i]) v[i] = '0;
      1: foreach (v[i]) v[i] = '1;
      2: begin
        v[0] = RST_MOTION_ALARM;
        v[1] = RST_MOTION_WARN;
        v[2] = 19'(RST_PROX_ALARM);
        v[3] = 19'(RST_PROX_WARN);
        v[4] = 19'(RST_LIGHT_LOW);
      end
      3: foreach (v[i]) v[i] = 19'($urandom);
      default: begin
        v[0] = 19'($urandom_range(3000, 40000));
        v[1] = 19'($urandom_range(500, v[0]));
        v[2] = 19'($urandom_range(50, 900));
        v[3] = 19'($urandom_range(10, v[2]));
        v[4] = 19'($urandom_range(0, 3000));
      end
    endcase
    write_reg(REG_MOTION_ALARM, v[0]);
    write_reg(REG_MOTION_WARN, v[1]);
    write_reg(REG_PROX_ALARM, v[2]);
    write_reg(REG_PROX_WARN, v[3]);
    write_reg(REG_LIGHT_LOW, v[4]);
    write_reg(3'($urandom_range(REG_SPARE, REG_LIGHT_LOW + 1)), 19'($urandom));
  endtask

  task automatic wait_idle();
    while (samples_q.size() != 0 || sample_valid || graded_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---- sample driver: bursts of random length with random gaps ----
  sample_t     nxt;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall)
        graded_q.push_back(classify_sample(nxt));
      if (!sample_valid || !sample_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          sample_valid <= 1'b0;
        end else if (samples_q.size() != 0) begin
          nxt = samples_q.pop_front();
          op            <= nxt.op;
          accel_x       <= nxt.axes[0];
          accel_y       <= nxt.axes[1];
          accel_z       <= nxt.axes[2];
          gyro_x        <= nxt.axes[3];
          gyro_y        <= nxt.axes[4];
          gyro_z        <= nxt.axes[5];
          motion_valid  <= nxt.motion_valid;
          ambient_light <= nxt.ambient_light;
          proximity     <= nxt.proximity;
          light_valid   <= nxt.light_valid;
          sample_valid  <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // ---- result stall pattern, with a long hold-off now and then ----
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 150;
  logic [1:0]  stall_tick = '0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (results_seen >= next_hold_at) begin
      hold_left <= HOLD_LEN;
      next_hold_at <= next_hold_at + $urandom_range(250, 450);
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= 1'($urandom_range(0, 1));
        2: result_stall <= (stall_tick == 2'd0);
        default: result_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // ---- result monitor ----
  task automatic cmp(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  result_t want;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen <= results_seen + 1;
      if (graded_q.size() == 0) begin
        err_count++;
        if (err_count <= 30) $error("result transaction with nothing expected");
      end else begin
        want = graded_q.pop_front();
        cmp("grade", want.grade, grade);
        cmp("reason", want.reason, reason);
        cmp("delta_sum", want.delta_sum, delta_sum);
        cmp("alarm_count", want.alarm_count, alarm_count);
        cmp("muted", want.muted, muted);
        cmp("acknowledged", want.acknowledged, acknowledged);
        cmp("state_changed", want.state_changed, state_changed);
      end
    end
  end

  // ---- watchdog: cycles without any transaction ----
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- test sequence ----
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    load_directed();
    for (int k = 0; k < 8; k++) begin
      wait_idle();
      program_limits(k);
      load_random(93);
    end
    wait_idle();
    program_limits(2);
    load_random(30);
    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sac_pkg.sv
hw/rtl/sac_motion.sv
hw/rtl/sac_grade.sv
hw/rtl/sensor_alarm_classifier.sv
dv/tb_sensor_alarm_classifier.sv
